FILE: hdl/hash_insert_linear_probe_unit_macros.svh
// Assertion macros for the linear probe hash insert unit.
// Included by files that check their own logic; no other dependencies.
// Define NO_ASSERTIONS to compile every check away.
`ifndef HASH_INSERT_LINEAR_PROBE_UNIT_MACROS_SVH
`define HASH_INSERT_LINEAR_PROBE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is low
`define HILP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hilp check failed");

// Next-cycle implication, disabled while reset is low
`define HILP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hilp check failed");

`else

`define HILP_ASSERT(label, clk, rst_n, ante, cons)

`define HILP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/hilp_pkg.sv
// Shared types and constants of the linear probe hash insert unit.
// No dependencies; used by the channel interface users, the slot RAM and the top level.
`default_nettype none

package hilp_pkg;

    // Field widths
    localparam int SIZE_W   = 7;
    localparam int CHAR_W   = 8;
    localparam int MILE_W   = 31;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    // Table size after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Residue plus one byte stays below 2^9; reduced three bits per cycle
    localparam int SUM_W         = 9;
    localparam int MOD_PER_CYCLE = 3;
    localparam int MOD_CYCLES    = SUM_W / MOD_PER_CYCLE;
    localparam int MOD_SHIFT_W   = 16;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] key_char;
        logic              key_last;
        logic [MILE_W-1:0] mileage;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
    } t_out_word;

    // One table entry as held in the slot RAM
    typedef struct packed {
        logic              used;
        logic [MILE_W-1:0] mileage;
    } t_slot_word;

endpackage

`default_nettype wire

FILE: hdl/hilp_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
// No dependencies; the payload type is supplied by the instantiating scope.
`default_nettype none

interface hilp_chan_if #(parameter type T = logic) ();

    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: hdl/hilp_slot_ram.sv
// Slot table RAM: one write port, one read port, registered read data.
// Depends on hilp_pkg for the slot word type.
`default_nettype none

module hilp_slot_ram
    import hilp_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_slot_word    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_slot_word         o_rdata
);

    t_slot_word r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/hash_insert_linear_probe_unit.sv
// Linear probe hash insert unit. Key bytes arrive one word each; the byte is
// added to a running residue that is reduced mod the table size in the S_MOD
// state. On the last byte the probe walks the slot RAM from the home slot,
// wrapping at the table size, reading each slot (S_RD), then checking it and
// claiming it if free (S_CHK), and posts the result from S_EMIT. With table
// size zero no residue is formed and a last byte goes straight to S_EMIT with
// the zero status. After reset a clearing pass empties the slot RAM; no key
// byte is taken until it ends. The result sits in an output register, so new
// bytes are taken while it waits.
// Depends on hilp_pkg, hilp_chan_if, hilp_slot_ram and the macros header.
`default_nettype none

`include "hash_insert_linear_probe_unit_macros.svh"

module hash_insert_linear_probe_unit
    import hilp_pkg::*;
#(
    parameter int SLOT_COUNT = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata,
    hilp_chan_if.sink              i_in,
    hilp_chan_if.source            o_out
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK,
        S_EMIT
    } t_state;

    // Control registers
    t_state            r_state,      n_state;
    logic [AW-1:0]     r_clr_addr,   n_clr_addr;
    logic [SIZE_W-1:0] r_table_size, n_table_size;
    logic [SIZE_W-1:0] r_size,       n_size;
    logic [SIZE_W-1:0] r_residue,    n_residue;
    logic [1:0]        r_mod_step,   n_mod_step;
    logic              r_out_valid,  n_out_valid;

    // Payload registers
    logic [SUM_W-1:0]  r_mod_val,    n_mod_val;
    logic              r_last,       n_last;
    logic [MILE_W-1:0] r_miles,      n_miles;
    logic [AW-1:0]     r_idx,        n_idx;
    logic [SIZE_W-1:0] r_probe_cnt,  n_probe_cnt;
    t_out_word         r_res,        n_res;
    t_out_word         r_out_word,   n_out_word;

    logic [SIZE_W-1:0]      w_live;
    logic                   w_in_acc;
    logic                   w_out_free;
    logic [SUM_W-1:0]       w_mod_v;
    logic [MOD_SHIFT_W-1:0] w_mod_t;
    logic [3:0]             w_mod_sh;
    logic [CW-1:0]          w_home_ext;
    logic [CW-1:0]          w_next_ext;
    logic [CW-1:0]          w_idx_ext;
    logic [SIZE_W:0]        w_cnt_inc;
    logic                   w_hit;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    t_slot_word             w_wdata;
    t_slot_word             w_rdata;

    // Slot table storage
    hilp_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Table size in use, saturated to the slot count
    always_comb begin
        if (CW'(r_table_size) > CW'(SLOT_COUNT)) begin
            w_live = SIZE_W'(SLOT_COUNT);
        end else begin
            w_live = r_table_size;
        end
    end

    assign w_in_acc   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;

    // Three restoring-remainder steps per cycle, highest shift first
    always_comb begin
        w_mod_v  = r_mod_val;
        w_mod_t  = '0;
        w_mod_sh = '0;
        for (int j = 0; j < MOD_PER_CYCLE; j++) begin
            w_mod_sh = 4'(SUM_W - 1 - j) - 4'(r_mod_step) * 4'(MOD_PER_CYCLE);
            w_mod_t  = MOD_SHIFT_W'(r_size) << w_mod_sh;
            if (MOD_SHIFT_W'(w_mod_v) >= w_mod_t) begin
                w_mod_v = w_mod_v - w_mod_t[SUM_W-1:0];
            end
        end
    end

    // Probe address arithmetic
    assign w_home_ext = CW'(w_mod_v);
    assign w_idx_ext  = CW'(r_idx);
    assign w_next_ext = w_idx_ext + CW'(1);
    assign w_cnt_inc  = {1'b0, r_probe_cnt} + (SIZE_W + 1)'(1);
    assign w_hit      = (r_state == S_CHK) && !w_rdata.used;

    // RAM write: clearing pass or claim of a free slot
    assign w_we    = (r_state == S_CLEAR) || w_hit;
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_idx;
    always_comb begin
        w_wdata = '0;
        if (r_state != S_CLEAR) begin
            w_wdata.used    = 1'b1;
            w_wdata.mileage = r_miles;
        end
    end

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_table_size = r_table_size;
        n_size       = r_size;
        n_residue    = r_residue;
        n_mod_step   = r_mod_step;
        n_out_valid  = r_out_valid;
        n_mod_val    = r_mod_val;
        n_last       = r_last;
        n_miles      = r_miles;
        n_idx        = r_idx;
        n_probe_cnt  = r_probe_cnt;
        n_res        = r_res;
        n_out_word   = r_out_word;

        if (i_cfg_we) begin
            n_table_size = i_cfg_wdata;
        end

        // Output register drains on a taken word
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_size  = w_live;
                    n_last  = i_in.payload.key_last;
                    n_miles = i_in.payload.mileage;
                    if (w_live == '0) begin
                        n_residue = '0;
                        if (i_in.payload.key_last) begin
                            n_res.status     = ST_ZERO;
                            n_res.slot_index = '0;
                            n_state          = S_EMIT;
                        end
                    end else begin
                        n_mod_val  = SUM_W'(r_residue) + SUM_W'(i_in.payload.key_char);
                        n_mod_step = '0;
                        n_state    = S_MOD;
                    end
                end
            end
            S_MOD: begin
                n_mod_val  = w_mod_v;
                n_mod_step = r_mod_step + 2'd1;
                if (r_mod_step == 2'(MOD_CYCLES - 1)) begin
                    if (r_last) begin
                        n_residue   = '0;
                        n_idx       = w_home_ext[AW-1:0];
                        n_probe_cnt = '0;
                        n_state     = S_RD;
                    end else begin
                        n_residue = w_mod_v[SIZE_W-1:0];
                        n_state   = S_IDLE;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!w_rdata.used) begin
                    n_res.status     = ST_INSERTED;
                    n_res.slot_index = w_idx_ext[SLOT_W-1:0];
                    n_state          = S_EMIT;
                end else if (w_cnt_inc == (SIZE_W + 1)'(r_size)) begin
                    n_res.status     = ST_FULL;
                    n_res.slot_index = '0;
                    n_state          = S_EMIT;
                end else begin
                    n_probe_cnt = w_cnt_inc[SIZE_W-1:0];
                    if (w_next_ext == CW'(r_size)) begin
                        n_idx = '0;
                    end else begin
                        n_idx = w_next_ext[AW-1:0];
                    end
                    n_state = S_RD;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_table_size <= SIZE_RESET;
            r_size       <= '0;
            r_residue    <= '0;
            r_mod_step   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_table_size <= n_table_size;
            r_size       <= n_size;
            r_residue    <= n_residue;
            r_mod_step   <= n_mod_step;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mod_val   <= n_mod_val;
        r_last      <= n_last;
        r_miles     <= n_miles;
        r_idx       <= n_idx;
        r_probe_cnt <= n_probe_cnt;
        r_res       <= n_res;
        r_out_word  <= n_out_word;
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_word;

    // Checks
    `HILP_ASSERT_NEXT(a_hit_reports_insert, i_clk, i_rst_n, w_hit, (r_state == S_EMIT) && (r_res.status == ST_INSERTED))
    `HILP_ASSERT(a_probe_cnt_in_range, i_clk, i_rst_n, r_state == S_RD, r_probe_cnt < r_size)
    `HILP_ASSERT(a_probe_idx_in_range, i_clk, i_rst_n, r_state == S_RD, w_idx_ext < CW'(r_size))
    `HILP_ASSERT(a_residue_reduced, i_clk, i_rst_n, (r_state == S_IDLE) && (r_size != '0), r_residue < r_size)

endmodule

`default_nettype wire
